### design/tsb_pkg.sv
// shared types and constants for the three-stack shared buffer
// no dependencies; imported by every module of the block
package tsb_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;

  // operation codes carried on kind
  localparam logic [KIND_W-1:0] KIND_PUSH_LOW  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_HIGH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_MID  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_LOW   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_HIGH  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP_MID   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_ACCESS,
    S_RDWAIT,
    S_RESP
  } state_e;

  // memory port strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

### design/tsb_mem.sv
// word store: one write port and one read port, registered read data
// depends on tsb_pkg
module tsb_mem #(
  parameter int DEPTH = tsb_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  tsb_pkg::mem_ctl_t            ctl_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  logic [tsb_pkg::WORD_W-1:0]   wdata_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [tsb_pkg::WORD_W-1:0]   rdata_o
);
  import tsb_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tsb_ctrl.sv
// sequencer: stack pointers, middle-stack relocation, push/pop access, result register
// depends on tsb_pkg; drives the ports of tsb_mem
module tsb_ctrl #(
  parameter int DEPTH = tsb_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tsb_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [tsb_pkg::WORD_W-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tsb_pkg::WORD_W-1:0]   pop_value_o,
  output logic [tsb_pkg::STATUS_W-1:0]        status_o,
  output tsb_pkg::mem_ctl_t                   mem_ctl_o,
  output logic [$clog2(DEPTH)-1:0]            mem_waddr_o,
  output logic [tsb_pkg::WORD_W-1:0]          mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]            mem_raddr_o,
  input  logic [tsb_pkg::WORD_W-1:0]          mem_rdata_i
);
  import tsb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] MID_RST = PW'((DEPTH - 1) / 2);

  state_e state_q, state_d;

  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [WORD_W-1:0]   value_q, value_d;
  // hnext is high_top plus one, so it never goes negative
  logic [PW-1:0]       low_q, low_d, hnext_q, hnext_d;
  logic [PW-1:0]       base_q, base_d, end_q, end_d;
  logic                up_q, up_d;
  logic [PW-1:0]       n_q, n_d, left_q, left_d, rd_addr_q, rd_addr_d;
  logic                wp_q, wp_d;
  logic [PW-1:0]       wa_q, wa_d;
  logic [WORD_W-1:0]   res_value_q, res_value_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   out_value_q, out_value_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic                accept, is_push, full, need_up, need_dn, err;
  logic [STATUS_W-1:0] err_status;
  logic [PW-1:0]       room, n_calc, hm1, wa_calc;
  logic                move_done, out_free;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign hm1      = hnext_q - PW'(1);
  assign wa_calc  = up_q ? (rd_addr_q + n_q) : (rd_addr_q - n_q);
  assign move_done = (left_q == '0) && !wp_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // decode of the arriving item against the current pointers
  always_comb begin
    is_push    = (kind_i == KIND_PUSH_LOW) || (kind_i == KIND_PUSH_HIGH) ||
                 (kind_i == KIND_PUSH_MID);
    full       = (low_q == base_q) && (end_q == hnext_q);
    need_up    = (kind_i == KIND_PUSH_LOW) && (low_q == base_q) && !full;
    need_dn    = ((kind_i == KIND_PUSH_HIGH) || (kind_i == KIND_PUSH_MID)) &&
                 (end_q == hnext_q) && (low_q != base_q);
    room       = need_up ? (hnext_q - end_q) : (base_q - low_q);
    n_calc     = (room >= PW'(2)) ? (room >> 1) : room;
    err        = 1'b0;
    err_status = ST_OK;
    case (kind_i)
      KIND_PUSH_LOW, KIND_PUSH_HIGH, KIND_PUSH_MID: begin
        err        = full;
        err_status = full ? ST_FULL : ST_OK;
      end
      KIND_POP_LOW: begin
        err        = (low_q == '0);
        err_status = err ? ST_EMPTY : ST_OK;
      end
      KIND_POP_HIGH: begin
        err        = (hnext_q == PW'(DEPTH));
        err_status = err ? ST_EMPTY : ST_OK;
      end
      KIND_POP_MID: begin
        err        = (end_q == base_q);
        err_status = err ? ST_EMPTY : ST_OK;
      end
      default: begin
        // undefined kind answers ok with zero and changes nothing
        err        = 1'b1;
        err_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (err) begin
            state_d = S_RESP;
          end else if (is_push && (need_up || need_dn)) begin
            state_d = S_MOVE;
          end else begin
            state_d = S_ACCESS;
          end
        end
      end
      S_MOVE: begin
        if (move_done) begin
          state_d = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if ((kind_q == KIND_POP_LOW) || (kind_q == KIND_POP_HIGH) ||
            (kind_q == KIND_POP_MID)) begin
          state_d = S_RDWAIT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RDWAIT: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    kind_d       = kind_q;
    value_d      = value_q;
    low_d        = low_q;
    hnext_d      = hnext_q;
    base_d       = base_q;
    end_d        = end_q;
    up_d         = up_q;
    n_d          = n_q;
    left_d       = left_q;
    rd_addr_d    = rd_addr_q;
    wp_d         = wp_q;
    wa_d         = wa_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_ctl_o    = '0;
    mem_waddr_o  = '0;
    mem_wdata_o  = value_q;
    mem_raddr_o  = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d       = kind_i;
          value_d      = $unsigned(push_value_i);
          res_value_d  = '0;
          res_status_d = err_status;
          up_d         = need_up;
          n_d          = n_calc;
          left_d       = end_q - base_q;
          rd_addr_d    = need_up ? (end_q - PW'(1)) : base_q;
          wp_d         = 1'b0;
        end
      end
      S_MOVE: begin
        // read one word per cycle, write the previous read at its shifted address
        mem_ctl_o.rd_en = (left_q != '0);
        mem_raddr_o     = rd_addr_q[AW-1:0];
        mem_ctl_o.wr_en = wp_q;
        mem_waddr_o     = wa_q[AW-1:0];
        mem_wdata_o     = mem_rdata_i;
        wp_d            = (left_q != '0);
        wa_d            = wa_calc;
        if (left_q != '0) begin
          left_d    = left_q - PW'(1);
          rd_addr_d = up_q ? (rd_addr_q - PW'(1)) : (rd_addr_q + PW'(1));
        end
        if (move_done) begin
          base_d = up_q ? (base_q + n_q) : (base_q - n_q);
          end_d  = up_q ? (end_q + n_q) : (end_q - n_q);
        end
      end
      S_ACCESS: begin
        case (kind_q)
          KIND_PUSH_LOW: begin
            mem_ctl_o.wr_en = 1'b1;
            mem_waddr_o     = low_q[AW-1:0];
            low_d           = low_q + PW'(1);
          end
          KIND_PUSH_HIGH: begin
            mem_ctl_o.wr_en = 1'b1;
            mem_waddr_o     = hm1[AW-1:0];
            hnext_d         = hm1;
          end
          KIND_PUSH_MID: begin
            mem_ctl_o.wr_en = 1'b1;
            mem_waddr_o     = end_q[AW-1:0];
            end_d           = end_q + PW'(1);
          end
          KIND_POP_LOW: begin
            mem_ctl_o.rd_en = 1'b1;
            mem_raddr_o     = AW'(low_q - PW'(1));
            low_d           = low_q - PW'(1);
          end
          KIND_POP_HIGH: begin
            mem_ctl_o.rd_en = 1'b1;
            mem_raddr_o     = hnext_q[AW-1:0];
            hnext_d         = hnext_q + PW'(1);
          end
          KIND_POP_MID: begin
            mem_ctl_o.rd_en = 1'b1;
            mem_raddr_o     = AW'(end_q - PW'(1));
            end_d           = end_q - PW'(1);
          end
          default: ;
        endcase
      end
      S_RDWAIT: begin
        res_value_d = mem_rdata_i;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      low_q       <= '0;
      hnext_q     <= PW'(DEPTH);
      base_q      <= MID_RST;
      end_q       <= MID_RST;
      left_q      <= '0;
      wp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      hnext_q     <= hnext_d;
      base_q      <= base_d;
      end_q       <= end_d;
      left_q      <= left_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    value_q      <= value_d;
    up_q         <= up_d;
    n_q          <= n_d;
    rd_addr_q    <= rd_addr_d;
    wa_q         <= wa_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pop_value_o = $signed(out_value_q);
  assign status_o    = out_status_q;

endmodule

### design/three_stack_shared_buffer_core.sv
// Three stacks in one word memory of DEPTH entries: low stack from address 0 upward,
// high stack from DEPTH-1 downward, middle stack in a movable window growing upward.
// One item is taken at a time. A push passes through the access and response states, a pop
// through the access, read-wait and response states, and a full, empty or undefined-kind
// answer goes straight to the response state; the result valid is registered. When a push
// must first relocate the middle stack, a move state comes before the access state; the
// sequencer copies one word per cycle through the single read and single write port of
// the memory, and the last write lands in the cycle after the last read. A new item
// is taken as soon as the sequencer is back to idle, even while the previous result still
// waits on the output register. The store needs no clearing after reset; only words that
// were pushed are ever read.
// depends on tsb_pkg, tsb_mem, tsb_ctrl
module three_stack_shared_buffer_core #(
  parameter int DEPTH = tsb_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tsb_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [tsb_pkg::WORD_W-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tsb_pkg::WORD_W-1:0]   pop_value_o,
  output logic [tsb_pkg::STATUS_W-1:0]        status_o
);
  import tsb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  tsb_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .mem_ctl_o    (mem_ctl),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tsb_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // relocation never reads a word in the same cycle it is overwritten
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.wr_en && mem_ctl.rd_en) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same word in one cycle");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> (32'(mem_waddr) < DEPTH))
    else $error("write address beyond the store");

  a_raddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.rd_en |-> (32'(mem_raddr) < DEPTH))
    else $error("read address beyond the store");

  // a result never appears in the cycle right after its input transfer
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result valid too early after input transfer");

endmodule
